// ===== rtl/utce_pkg.sv =====
// shared types, constants and tables for the utc date to epoch seconds converter
`timescale 1ns / 1ps

package utce_pkg;

    // range limits for the input fields
    localparam logic [15:0] MIN_YEAR   = 16'd2024;
    localparam logic [7:0]  MAX_MONTH  = 8'd12;
    localparam logic [7:0]  MAX_DAY    = 8'd31;
    localparam logic [7:0]  MAX_HOUR   = 8'd23;
    localparam logic [7:0]  MAX_MINUTE = 8'd59;
    localparam logic [7:0]  MAX_SECOND = 8'd59;

    // calendar constants
    localparam logic [8:0]  YEARS_PER_ERA    = 9'd400;
    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
    localparam logic [17:0] DAYS_PER_ERA     = 18'd146097;
    localparam logic [19:0] EPOCH_DAY_OFFSET = 20'd719468;
    localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE  = 6'd60;

    // reciprocals of 25: q16 exact for x < 4681, q10 exact for x < 1024
    localparam logic [11:0] RECIP25_Q16 = 12'd2622;
    localparam logic [5:0]  RECIP25_Q10 = 6'd41;

    // widths of intermediate values
    localparam int ERA_W  = 8;
    localparam int DOY_W  = 9;
    localparam int YOE_W  = 9;
    localparam int DOE_W  = 18;
    localparam int DAYS_W = 25;
    localparam int TOD_W  = 17;
    localparam int EPOCH_W = 41;

    // register stages inside the day counter
    localparam int DAYS_LAT = 4;

    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } req_t;

    typedef struct packed {
        logic               valid_res;
        logic [EPOCH_W-1:0] epoch_seconds;
    } res_t;

    // march-based date handed to the day counter
    typedef struct packed {
        logic [15:0] yy;
        logic [3:0]  mp;
        logic [4:0]  dom;
    } date_t;

    // day counter result
    typedef struct packed {
        logic              valid;
        logic [DAYS_W-1:0] days;
    } days_t;

    // days before the first of each month, year starting in march
    function automatic logic [DOY_W-1:0] month_offset(input logic [3:0] mp);
        logic [DOY_W-1:0] ofs;
        case (mp)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// ===== rtl/utc_date_to_epoch_seconds.sv =====
// top level: utc date and time to unix epoch seconds, six-stage pipeline
`timescale 1ns / 1ps

// Converts one UTC date and time to seconds since 1970-01-01 00:00:00 UTC.
// A transfer is taken at every rising edge where start is high and busy is
// low; busy is never raised, so a new item may enter on every clock and the
// block sustains one conversion per cycle. Each item comes back as a
// single-cycle done strobe with result after passing the six register
// stages (range check and time of day, era by reciprocal multiply, year of
// era, day of era, day count, day count times 86400), each holding no more
// than two constant multiplies and a short add chain. The receiver cannot
// hold results off, and none is ever dropped. Fields are
// checked as year at least 2024, month 1 to 12, day 1 to 31 (no month-length
// check, so February 31 rolls into March), hour up to 23, minute and second
// up to 59. A failed check returns valid_res 0 with epoch_seconds 0. Year
// 65535 still fits the 41-bit result.

module utc_date_to_epoch_seconds (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  utce_pkg::req_t  req,
    output logic            done,
    output utce_pkg::res_t  result
);

    // stage 1: range check, march-based date, time of day
    logic                          s1_valid_reg;
    logic                          s1_ok_reg;
    logic                          s1_ok_next;
    utce_pkg::date_t               s1_date_reg;
    utce_pkg::date_t               s1_date_next;
    logic [utce_pkg::TOD_W-1:0]    s1_tod_reg;
    logic [19:0]                   hour_secs;
    logic [13:0]                   min_secs;
    logic [19:0]                   tod_sum;
    logic                          early_month;

    // side band that travels next to the day counter
    logic                          ok_dly_reg  [utce_pkg::DAYS_LAT];
    logic [utce_pkg::TOD_W-1:0]    tod_dly_reg [utce_pkg::DAYS_LAT];

    utce_pkg::days_t               days_out;

    // output stage
    logic                          done_reg;
    utce_pkg::res_t                result_reg;
    utce_pkg::res_t                result_next;
    logic [41:0]                   day_secs;
    logic [41:0]                   epoch_sum;

    // never stalls: every cycle can take a new transfer
    assign busy = 1'b0;

    assign s1_ok_next = (req.year >= utce_pkg::MIN_YEAR)
                     && (req.month != 8'd0) && (req.month <= utce_pkg::MAX_MONTH)
                     && (req.day != 8'd0) && (req.day <= utce_pkg::MAX_DAY)
                     && (req.hour <= utce_pkg::MAX_HOUR)
                     && (req.minute <= utce_pkg::MAX_MINUTE)
                     && (req.second <= utce_pkg::MAX_SECOND);

    // january and february count as months of the previous year
    assign early_month       = (req.month <= 8'd2);
    assign s1_date_next.yy   = req.year - {15'd0, early_month};
    assign s1_date_next.mp   = early_month ? (req.month[3:0] + 4'd9)
                                           : (req.month[3:0] - 4'd3);
    assign s1_date_next.dom  = req.day[4:0];

    // out-of-range fields only feed results that are zeroed later
    assign hour_secs = {12'd0, req.hour} * {8'd0, utce_pkg::SECS_PER_HOUR};
    assign min_secs  = {6'd0, req.minute} * {8'd0, utce_pkg::SECS_PER_MINUTE};
    assign tod_sum   = hour_secs + {6'd0, min_secs} + {12'd0, req.second};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            done_reg     <= days_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg   <= s1_ok_next;
        s1_date_reg <= s1_date_next;
        s1_tod_reg  <= tod_sum[16:0];
    end

    utce_days u_days (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (s1_valid_reg),
        .date   (s1_date_reg),
        .result (days_out)
    );

    // keep check result and time of day aligned with the day count
    always_ff @(posedge clk)
    begin
        ok_dly_reg[0]  <= s1_ok_reg;
        tod_dly_reg[0] <= s1_tod_reg;
        for (int i = 1; i < utce_pkg::DAYS_LAT; i++)
        begin
            ok_dly_reg[i]  <= ok_dly_reg[i-1];
            tod_dly_reg[i] <= tod_dly_reg[i-1];
        end
    end

    // seconds = days * 86400 + time of day, zero when a check failed
    assign day_secs  = {17'd0, days_out.days} * {25'd0, utce_pkg::SECS_PER_DAY};
    assign epoch_sum = day_secs + {25'd0, tod_dly_reg[utce_pkg::DAYS_LAT-1]};

    always_comb
    begin
        result_next.valid_res = ok_dly_reg[utce_pkg::DAYS_LAT-1];
        if (ok_dly_reg[utce_pkg::DAYS_LAT-1])
        begin
            result_next.epoch_seconds = epoch_sum[40:0];
        end
        else
        begin
            result_next.epoch_seconds = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every accepted transfer is followed by a done strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
    else $error("accepted transfer did not produce a result after six cycles");

    // no result without a matching accepted transfer before it
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
    else $error("result strobe without matching transfer");

    // a failed range check always reports zero seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.valid_res) |-> (result.epoch_seconds == '0))
    else $error("invalid result carries nonzero seconds");

    // a valid result can never precede 2024-01-01 00:00:00
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.valid_res) |-> (result.epoch_seconds >= 41'd1704067200))
    else $error("valid result earlier than the minimum year");
`endif

endmodule

// ===== rtl/utce_days.sv =====
// four-stage day counter: march-based date to days since 1970-01-01
`timescale 1ns / 1ps

module utce_days (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  utce_pkg::date_t  date,
    output utce_pkg::days_t  result
);

    // stage 2: era and day of year
    logic                          s2_valid_reg;
    logic [15:0]                   s2_yy_reg;
    logic [utce_pkg::ERA_W-1:0]    s2_era_reg;
    logic [utce_pkg::DOY_W-1:0]    s2_doy_reg;
    logic [23:0]                   era_prod;
    logic [utce_pkg::ERA_W-1:0]    s2_era_next;
    logic [utce_pkg::DOY_W-1:0]    s2_doy_next;

    // stage 3: year of era
    logic                          s3_valid_reg;
    logic [utce_pkg::ERA_W-1:0]    s3_era_reg;
    logic [utce_pkg::DOY_W-1:0]    s3_doy_reg;
    logic [utce_pkg::YOE_W-1:0]    s3_yoe_reg;
    logic [15:0]                   era_years;
    logic [15:0]                   yoe_full;

    // stage 4: day of era
    logic                          s4_valid_reg;
    logic [utce_pkg::ERA_W-1:0]    s4_era_reg;
    logic [utce_pkg::DOE_W-1:0]    s4_doe_reg;
    logic [utce_pkg::DOE_W-1:0]    yoe_days;
    logic [6:0]                    leap4;
    logic [12:0]                   cent_prod;
    logic [utce_pkg::DOE_W-1:0]    s4_doe_next;

    // stage 5: days since epoch
    logic                          s5_valid_reg;
    logic [utce_pkg::DAYS_W-1:0]   s5_days_reg;
    logic [25:0]                   era_days;
    logic [25:0]                   days_sum;

    // yy / 400 as (yy >> 4) / 25 via reciprocal
    assign era_prod    = {12'd0, date.yy[15:4]} * {12'd0, utce_pkg::RECIP25_Q16};
    assign s2_era_next = era_prod[23:16];
    assign s2_doy_next = utce_pkg::month_offset(date.mp)
                       + {4'd0, date.dom} - 9'd1;

    assign era_years = {8'd0, s2_era_reg} * {7'd0, utce_pkg::YEARS_PER_ERA};
    assign yoe_full  = s2_yy_reg - era_years;

    // yoe * 365 + yoe / 4 - yoe / 100 + doy
    assign yoe_days  = {9'd0, s3_yoe_reg} * {9'd0, utce_pkg::DAYS_PER_YEAR};
    assign leap4     = s3_yoe_reg[8:2];
    assign cent_prod = {6'd0, leap4} * {7'd0, utce_pkg::RECIP25_Q10};
    assign s4_doe_next = yoe_days + {11'd0, leap4} - {15'd0, cent_prod[12:10]}
                       + {9'd0, s3_doy_reg};

    assign era_days = {18'd0, s4_era_reg} * {8'd0, utce_pkg::DAYS_PER_ERA};
    assign days_sum = era_days + {8'd0, s4_doe_reg}
                    - {6'd0, utce_pkg::EPOCH_DAY_OFFSET};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_yy_reg   <= date.yy;
        s2_era_reg  <= s2_era_next;
        s2_doy_reg  <= s2_doy_next;
        s3_era_reg  <= s2_era_reg;
        s3_doy_reg  <= s2_doy_reg;
        s3_yoe_reg  <= yoe_full[8:0];
        s4_era_reg  <= s3_era_reg;
        s4_doe_reg  <= s4_doe_next;
        s5_days_reg <= days_sum[24:0];
    end

    assign result.valid = s5_valid_reg;
    assign result.days  = s5_days_reg;

endmodule
